// ===== sv/ect_pkg.sv =====
`default_nettype none

package ect_pkg;

   // Position counter width and saturation point
   localparam int unsigned MAX_LEN   = 1024;
   localparam int unsigned POS_W     = 10;
   localparam logic [POS_W-1:0] POS_LIMIT =
      (MAX_LEN - 1 > 1023) ? POS_W'(1023) : POS_W'(MAX_LEN - 1);

   // Result queue depth
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = 2;
   localparam int unsigned QCNT_W = 3;

   // Token kinds
   localparam logic [2:0] KIND_END      = 3'd0;
   localparam logic [2:0] KIND_SINGLE   = 3'd1;
   localparam logic [2:0] KIND_COMPOUND = 3'd2;
   localparam logic [2:0] KIND_NUMBER   = 3'd3;
   localparam logic [2:0] KIND_NAME     = 3'd4;
   localparam logic [2:0] KIND_BADNUM   = 3'd5;

   // Characters of interest
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_E_UP   = 8'h45;
   localparam logic [7:0] CH_E_LO   = 8'h65;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRK   = 8'h5B;
   localparam logic [7:0] CH_RBRK   = 8'h5D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // Number phases
   localparam logic [1:0] PH_MANT  = 2'd0;
   localparam logic [1:0] PH_FRAC  = 2'd1;
   localparam logic [1:0] PH_EMARK = 2'd2;
   localparam logic [1:0] PH_EXP   = 2'd3;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_ANGLE  = 3'd1,
      MODE_NUMBER = 3'd2,
      MODE_NAME   = 3'd3,
      MODE_DEAD   = 3'd4
   } mode_type;

   typedef struct packed {
      logic [2:0]       kind;
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] length;
      logic [7:0]       first_char;
      logic [7:0]       second_char;
      logic             last;
   } token_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_single(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
             (c == CH_SLASH) || (c == CH_LPAR) || (c == CH_RPAR) ||
             (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_CARET) ||
             (c == CH_COLON) || (c == CH_EQ) || (c == CH_COMMA);
   endfunction

   function automatic token_type make_token(input logic [2:0] kind,
                                            input logic [POS_W-1:0] start,
                                            input logic [POS_W-1:0] length,
                                            input logic [7:0] c1,
                                            input logic [7:0] c2,
                                            input logic last);
      token_type t;
      t.kind        = kind;
      t.start       = start;
      t.length      = length;
      t.first_char  = c1;
      t.second_char = c2;
      t.last        = last;
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== sv/expression_char_tokenizer.sv =====
`default_nettype none

// Character tokenizer for arithmetic expressions. One character (or an
// end-of-text beat) is taken per clock while req_stall is low; its tokens are
// worked out in the same cycle from the scanner state and land in a four-entry
// result queue, so the first result is offered in the cycle after acceptance.
// A character yields zero, one or two tokens; the queue drains one token per
// cycle while rsp_stall is low, and req_stall rises whenever fewer than two
// queue slots are free, so the input rate is one character per cycle as long
// as the output keeps up with the tokens produced. Positions saturate at 1023;
// after an invalid number everything up to end of text is ignored.
module expression_char_tokenizer (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_ch,
   input  wire logic                      req_is_end,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [2:0]                     rsp_kind,
   output logic [ect_pkg::POS_W-1:0]      rsp_start_res,
   output logic [ect_pkg::POS_W-1:0]      rsp_length,
   output logic [7:0]                     rsp_first_char,
   output logic [7:0]                     rsp_second_char,
   output logic                           rsp_last
);

   // Scanner state
   logic [ect_pkg::POS_W-1:0] pos_ff, pos_in;
   ect_pkg::mode_type         mode_ff, mode_in;
   logic [1:0]                phase_ff, phase_in;
   logic [2:0]                seen_ff, seen_in;
   logic [ect_pkg::POS_W-1:0] start_ff, start_in;
   logic [7:0]                angle_ff, angle_in;

   // Result queue
   ect_pkg::token_type        q_mem [ect_pkg::QDEPTH];
   logic [ect_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [ect_pkg::QCNT_W-1:0] cnt_ff;

   logic                      accept;
   logic                      pop;
   logic [1:0]                n_tok;
   ect_pkg::token_type        tok0, tok1;

   // Start-of-token decode, used when a character opens a new token
   ect_pkg::mode_type         st_mode;
   logic                      st_emit;
   logic                      st_set_start;
   logic                      st_set_angle;
   logic [1:0]                st_phase;
   logic [2:0]                st_seen;
   ect_pkg::token_type        st_tok;

   // Number step
   logic [1:0]                ns_result;   // 0 taken, 1 ends, 2 bad
   logic [1:0]                ns_phase;
   logic [2:0]                ns_seen;
   logic                      num_ok;

   logic [ect_pkg::POS_W-1:0] len;
   logic                      c_is_e;

   assign accept = req_valid && !req_stall;
   assign pop    = rsp_valid && !rsp_stall;
   assign len    = pos_ff - start_ff;
   assign c_is_e = (req_ch == ect_pkg::CH_E_UP) || (req_ch == ect_pkg::CH_E_LO);

   // Decode what a character does when it opens a token
   always_comb begin
      st_mode      = ect_pkg::MODE_IDLE;
      st_emit      = 1'b0;
      st_set_start = 1'b0;
      st_set_angle = 1'b0;
      st_phase     = phase_ff;
      st_seen      = seen_ff;
      st_tok       = ect_pkg::make_token(ect_pkg::KIND_SINGLE, pos_ff,
                        ect_pkg::POS_W'(1), req_ch, 8'h00, 1'b0);
      priority if (req_ch == ect_pkg::CH_SPACE) begin
         st_mode = ect_pkg::MODE_IDLE;
      end else if (req_ch == ect_pkg::CH_LT || req_ch == ect_pkg::CH_GT) begin
         st_mode      = ect_pkg::MODE_ANGLE;
         st_set_start = 1'b1;
         st_set_angle = 1'b1;
      end else if (ect_pkg::is_single(req_ch)) begin
         st_emit = 1'b1;
      end else if (req_ch == ect_pkg::CH_DOT) begin
         st_mode      = ect_pkg::MODE_NUMBER;
         st_set_start = 1'b1;
         st_phase     = ect_pkg::PH_FRAC;
         st_seen      = 3'b000;
      end else if (ect_pkg::is_digit(req_ch)) begin
         st_mode      = ect_pkg::MODE_NUMBER;
         st_set_start = 1'b1;
         st_phase     = ect_pkg::PH_MANT;
         st_seen      = 3'b001;
      end else begin
         st_mode      = ect_pkg::MODE_NAME;
         st_set_start = 1'b1;
      end
   end

   // Advance the number machine by one character
   always_comb begin
      ns_result = 2'd0;
      ns_phase  = phase_ff;
      ns_seen   = seen_ff;
      unique case (phase_ff)
         ect_pkg::PH_MANT: begin
            priority if (req_ch == ect_pkg::CH_DOT) ns_phase = ect_pkg::PH_FRAC;
            else if (c_is_e) ns_phase = ect_pkg::PH_EMARK;
            else if (ect_pkg::is_digit(req_ch)) ns_seen[0] = 1'b1;
            else ns_result = 2'd1;
         end
         ect_pkg::PH_FRAC: begin
            priority if (req_ch == ect_pkg::CH_DOT) ns_result = 2'd2;
            else if (c_is_e) ns_phase = ect_pkg::PH_EMARK;
            else if (ect_pkg::is_digit(req_ch)) ns_seen[1] = 1'b1;
            else ns_result = 2'd1;
         end
         ect_pkg::PH_EMARK: begin
            priority if (req_ch == ect_pkg::CH_PLUS || req_ch == ect_pkg::CH_MINUS) begin
               ns_phase = ect_pkg::PH_EXP;
            end else if (ect_pkg::is_digit(req_ch)) begin
               ns_seen[2] = 1'b1;
               ns_phase   = ect_pkg::PH_EXP;
            end else begin
               ns_result = 2'd1;
            end
         end
         default: begin
            if (ect_pkg::is_digit(req_ch)) ns_seen[2] = 1'b1;
            else ns_result = 2'd1;
         end
      endcase
   end

   // Validity of the number as it stands before this character
   assign num_ok = (seen_ff[1:0] != 2'b00) && (phase_ff != ect_pkg::PH_EMARK) &&
                   !(phase_ff == ect_pkg::PH_EXP && !seen_ff[2]);

   // Main scanner step: next state and tokens for this beat
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      seen_in  = seen_ff;
      start_in = start_ff;
      angle_in = angle_ff;
      pos_in   = (pos_ff < ect_pkg::POS_LIMIT) ? pos_ff + ect_pkg::POS_W'(1)
                                                : ect_pkg::POS_LIMIT;
      n_tok    = 2'd0;
      tok0     = ect_pkg::make_token(ect_pkg::KIND_END, pos_ff, '0, 8'h00, 8'h00, 1'b1);
      tok1     = tok0;

      // End-of-text beat: flush any open token, then emit the end token
      if (req_is_end) begin
         unique case (mode_ff)
            ect_pkg::MODE_ANGLE: begin
               tok0  = ect_pkg::make_token(ect_pkg::KIND_SINGLE, start_ff,
                          ect_pkg::POS_W'(1), angle_ff, 8'h00, 1'b0);
               n_tok = 2'd2;
            end
            ect_pkg::MODE_NUMBER: begin
               if (num_ok) tok0 = ect_pkg::make_token(ect_pkg::KIND_NUMBER, start_ff,
                                     len, 8'h00, 8'h00, 1'b0);
               else        tok0 = ect_pkg::make_token(ect_pkg::KIND_BADNUM, pos_ff,
                                     '0, 8'h00, 8'h00, 1'b0);
               n_tok = 2'd2;
            end
            ect_pkg::MODE_NAME: begin
               tok0  = ect_pkg::make_token(ect_pkg::KIND_NAME, start_ff, len,
                          8'h00, 8'h00, 1'b0);
               n_tok = 2'd2;
            end
            default: begin
               n_tok = 2'd1;
            end
         endcase
         tok1     = ect_pkg::make_token(ect_pkg::KIND_END, pos_ff, '0, 8'h00, 8'h00, 1'b1);
         mode_in  = ect_pkg::MODE_IDLE;
         phase_in = ect_pkg::PH_MANT;
         seen_in  = 3'b000;
         start_in = '0;
         angle_in = 8'h00;
         pos_in   = '0;
      end else begin
         unique case (mode_ff)
            ect_pkg::MODE_DEAD: begin
               mode_in = ect_pkg::MODE_DEAD;
            end
            ect_pkg::MODE_ANGLE: begin
               if (req_ch == ect_pkg::CH_EQ ||
                   (angle_ff == ect_pkg::CH_LT && req_ch == ect_pkg::CH_GT)) begin
                  tok0    = ect_pkg::make_token(ect_pkg::KIND_COMPOUND, start_ff,
                               ect_pkg::POS_W'(2), angle_ff, req_ch, 1'b0);
                  n_tok   = 2'd1;
                  mode_in = ect_pkg::MODE_IDLE;
               end else begin
                  tok0  = ect_pkg::make_token(ect_pkg::KIND_SINGLE, start_ff,
                             ect_pkg::POS_W'(1), angle_ff, 8'h00, 1'b0);
                  tok1  = st_tok;
                  n_tok = st_emit ? 2'd2 : 2'd1;
                  mode_in  = st_mode;
                  phase_in = st_phase;
                  seen_in  = st_seen;
                  if (st_set_start) start_in = pos_ff;
                  if (st_set_angle) angle_in = req_ch;
               end
            end
            ect_pkg::MODE_NUMBER: begin
               priority if (ns_result == 2'd0) begin
                  phase_in = ns_phase;
                  seen_in  = ns_seen;
               end else if (ns_result == 2'd2 || !num_ok) begin
                  tok0    = ect_pkg::make_token(ect_pkg::KIND_BADNUM, pos_ff, '0,
                               8'h00, 8'h00, 1'b0);
                  n_tok   = 2'd1;
                  mode_in = ect_pkg::MODE_DEAD;
               end else begin
                  tok0  = ect_pkg::make_token(ect_pkg::KIND_NUMBER, start_ff, len,
                             8'h00, 8'h00, 1'b0);
                  tok1  = st_tok;
                  n_tok = st_emit ? 2'd2 : 2'd1;
                  mode_in  = st_mode;
                  phase_in = st_phase;
                  seen_in  = st_seen;
                  if (st_set_start) start_in = pos_ff;
                  if (st_set_angle) angle_in = req_ch;
               end
            end
            ect_pkg::MODE_NAME: begin
               if (ect_pkg::is_single(req_ch) || req_ch == ect_pkg::CH_LT ||
                   req_ch == ect_pkg::CH_GT || req_ch == ect_pkg::CH_SPACE) begin
                  tok0  = ect_pkg::make_token(ect_pkg::KIND_NAME, start_ff, len,
                             8'h00, 8'h00, 1'b0);
                  tok1  = st_tok;
                  n_tok = st_emit ? 2'd2 : 2'd1;
                  mode_in  = st_mode;
                  phase_in = st_phase;
                  seen_in  = st_seen;
                  if (st_set_start) start_in = pos_ff;
                  if (st_set_angle) angle_in = req_ch;
               end
            end
            default: begin
               tok0     = st_tok;
               n_tok    = st_emit ? 2'd1 : 2'd0;
               mode_in  = st_mode;
               phase_in = st_phase;
               seen_in  = st_seen;
               if (st_set_start) start_in = pos_ff;
               if (st_set_angle) angle_in = req_ch;
            end
         endcase
      end
   end

   // Scanner registers: advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         mode_ff  <= ect_pkg::MODE_IDLE;
         phase_ff <= ect_pkg::PH_MANT;
         seen_ff  <= 3'b000;
         start_ff <= '0;
         angle_ff <= 8'h00;
      end else if (accept) begin
         pos_ff   <= pos_in;
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
         start_ff <= start_in;
         angle_ff <= angle_in;
      end
   end

   // Queue storage: write up to two tokens per beat
   always_ff @(posedge clock) begin
      if (accept && n_tok != 2'd0) begin
         q_mem[wr_ff] <= tok0;
         if (n_tok == 2'd2) q_mem[wr_ff + ect_pkg::QPTR_W'(1)] <= tok1;
      end
   end

   // Queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (accept) wr_ff <= wr_ff + ect_pkg::QPTR_W'(n_tok);
         if (pop)    rd_ff <= rd_ff + ect_pkg::QPTR_W'(1);
         cnt_ff <= cnt_ff + (accept ? ect_pkg::QCNT_W'(n_tok) : '0)
                          - (pop ? ect_pkg::QCNT_W'(1) : '0);
      end
   end

   // Hold input while fewer than two slots are free
   assign req_stall = cnt_ff > ect_pkg::QCNT_W'(ect_pkg::QDEPTH - 2);

   // Drive the result beat from the queue head
   assign rsp_valid       = cnt_ff != '0;
   assign rsp_kind        = q_mem[rd_ff].kind;
   assign rsp_start_res   = q_mem[rd_ff].start;
   assign rsp_length      = q_mem[rd_ff].length;
   assign rsp_first_char  = q_mem[rd_ff].first_char;
   assign rsp_second_char = q_mem[rd_ff].second_char;
   assign rsp_last        = q_mem[rd_ff].last;

endmodule

`default_nettype wire
